>>> rtl/pbm_stream_parser_top_assert.svh
// ----------------------------------------------------------------------------
// PBM stream parser assertion macros
// Implication checks on a clocked, reset-qualified property.
// ----------------------------------------------------------------------------
`ifndef PBM_STREAM_PARSER_TOP_ASSERT_SVH
`define PBM_STREAM_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define PBM_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pbm_stream_parser: assertion failed");

// next-cycle implication
`define PBM_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pbm_stream_parser: assertion failed");

`endif

>>> rtl/pbm_pkg.sv
// ----------------------------------------------------------------------------
// pbm_pkg
// Shared types and constants of the PBM stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pbm_pkg;

  localparam int MAX_DIM_DEFAULT = 16383;
  localparam int DIM_OUT_W       = 14;

  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_FOUR    = 8'h34;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_HEADER,
    KIND_ERROR
  } kind_t;

  typedef enum logic [2:0] {
    ERR_MAGIC,
    ERR_FORMAT,
    ERR_TRUNCATED,
    ERR_DIGIT,
    ERR_LARGE
  } err_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           pixel_byte;
    logic [DIM_OUT_W-1:0] img_width;
    logic [DIM_OUT_W-1:0] img_height;
    err_t                 error_code;
    logic                 last;
  } res_item_t;

endpackage

`default_nettype wire

>>> rtl/pbm_stream_if.sv
// ----------------------------------------------------------------------------
// pbm_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbm_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

>>> rtl/pbm_parser_core.sv
// ----------------------------------------------------------------------------
// pbm_parser_core
// Parser state and single-pass next-state logic: one byte in, at most one
// result out per advance.
// ----------------------------------------------------------------------------
`default_nettype none

module pbm_parser_core #(
  parameter int MAX_DIM = pbm_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire pbm_pkg::in_item_t item,
  output logic                   res_valid,
  output pbm_pkg::res_item_t     res
);

  import pbm_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int ACC_W = DIM_W + 4;

  typedef enum logic [2:0] {
    PH_MAGIC_P,
    PH_MAGIC_T,
    PH_W_SKIP,
    PH_W_NUM,
    PH_H_SKIP,
    PH_H_NUM,
    PH_RASTER,
    PH_IDLE
  } phase_t;

  phase_t           phase, phase_next;
  logic             ascii_format, ascii_format_next;
  logic             in_comment, in_comment_next;
  logic [DIM_W-1:0] number_accum, number_accum_next;
  logic [DIM_W-1:0] width_reg, width_reg_next;
  logic [DIM_W-1:0] height_reg, height_reg_next;
  logic [DIM_W-1:0] column_count, column_count_next;
  logic [DIM_W-1:0] row_count, row_count_next;
  logic [2:0]       bits_packed, bits_packed_next;
  logic [7:0]       pack_shift, pack_shift_next;

  logic [7:0]       b;
  logic             is_digit;
  logic [3:0]       d;
  logic [ACC_W-1:0] acc_val;
  logic [DIM_W:0]   width_sum;
  logic [DIM_W-1:0] bytes_per_row;
  logic [DIM_W-1:0] col_inc;
  logic [DIM_W-1:0] row_inc;
  logic [7:0]       shift_new;
  logic [2:0]       bits_new;
  logic [2:0]       width_lo;
  logic [7:0]       pad_mask;
  logic [7:0]       row_pix;
  logic             row_end;
  logic             empty;

  always_comb begin
    b             = item.in_byte;
    is_digit      = (b >= CH_ZERO) && (b <= CH_NINE);
    d             = b[3:0];
    acc_val       = ACC_W'({number_accum, 3'b000}) + ACC_W'({number_accum, 1'b0}) + ACC_W'(d);
    width_sum     = {1'b0, width_reg} + (DIM_W + 1)'(7);
    bytes_per_row = DIM_W'(width_sum >> 3);
    col_inc       = column_count + DIM_W'(1);
    row_inc       = row_count + DIM_W'(1);
    shift_new     = pack_shift | ((d == 4'd1) ? (8'h80 >> bits_packed) : 8'h00);
    bits_new      = bits_packed + 3'd1;
    width_lo      = 3'(width_reg);
    pad_mask      = (width_lo == 3'd0) ? 8'hFF : (8'hFF << (4'd8 - {1'b0, width_lo}));
    empty         = (width_reg == '0) || (number_accum == '0);

    phase_next        = phase;
    ascii_format_next = ascii_format;
    in_comment_next   = in_comment;
    number_accum_next = number_accum;
    width_reg_next    = width_reg;
    height_reg_next   = height_reg;
    column_count_next = column_count;
    row_count_next    = row_count;
    bits_packed_next  = bits_packed;
    pack_shift_next   = pack_shift;
    res_valid         = 1'b0;
    res               = '0;
    row_end           = 1'b0;
    row_pix           = 8'h00;

    if (go) begin
      if (item.end_of_stream) begin
        if (phase == PH_H_NUM && !in_comment && empty) begin
          res_valid      = 1'b1;
          res.kind       = KIND_HEADER;
          res.img_width  = DIM_OUT_W'(width_reg);
          res.img_height = DIM_OUT_W'(number_accum);
          res.last       = 1'b1;
        end else if (phase != PH_MAGIC_P && phase != PH_IDLE) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TRUNCATED;
          res.last       = 1'b1;
        end
        phase_next        = PH_MAGIC_P;
        ascii_format_next = 1'b0;
        in_comment_next   = 1'b0;
        number_accum_next = '0;
        width_reg_next    = '0;
        height_reg_next   = '0;
        column_count_next = '0;
        row_count_next    = '0;
        bits_packed_next  = '0;
        pack_shift_next   = '0;
      end else begin
        case (phase)
          PH_MAGIC_P: begin
            if (b == CH_P) begin
              phase_next = PH_MAGIC_T;
            end else begin
              phase_next     = PH_IDLE;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_MAGIC;
              res.last       = 1'b1;
            end
          end
          PH_MAGIC_T: begin
            if (b == CH_ONE || b == CH_FOUR) begin
              ascii_format_next = (b == CH_ONE);
              in_comment_next   = 1'b0;
              phase_next        = PH_W_SKIP;
            end else begin
              phase_next     = PH_IDLE;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_FORMAT;
              res.last       = 1'b1;
            end
          end
          PH_W_SKIP, PH_H_SKIP: begin
            if (in_comment) begin
              if (b == CH_NEWLINE) begin
                in_comment_next = 1'b0;
              end
            end else if (b == CH_HASH) begin
              in_comment_next = 1'b1;
            end else if (is_digit) begin
              if (ACC_W'(d) > ACC_W'(MAX_DIM)) begin
                phase_next     = PH_IDLE;
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_LARGE;
                res.last       = 1'b1;
              end else begin
                number_accum_next = DIM_W'(d);
                phase_next        = (phase == PH_W_SKIP) ? PH_W_NUM : PH_H_NUM;
              end
            end
          end
          PH_W_NUM, PH_H_NUM: begin
            if (is_digit) begin
              if (acc_val > ACC_W'(MAX_DIM)) begin
                phase_next     = PH_IDLE;
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_LARGE;
                res.last       = 1'b1;
              end else begin
                number_accum_next = DIM_W'(acc_val);
              end
            end else begin
              if (b == CH_HASH) begin
                in_comment_next = 1'b1;
              end
              number_accum_next = '0;
              if (phase == PH_W_NUM) begin
                width_reg_next = number_accum;
                phase_next     = PH_H_SKIP;
              end else begin
                height_reg_next   = number_accum;
                res_valid         = 1'b1;
                res.kind          = KIND_HEADER;
                res.img_width     = DIM_OUT_W'(width_reg);
                res.img_height    = DIM_OUT_W'(number_accum);
                res.last          = empty;
                phase_next        = empty ? PH_IDLE : PH_RASTER;
                column_count_next = '0;
                row_count_next    = '0;
                bits_packed_next  = '0;
                pack_shift_next   = '0;
              end
            end
          end
          PH_RASTER: begin
            if (in_comment) begin
              if (b == CH_NEWLINE) begin
                in_comment_next = 1'b0;
              end
            end else if (ascii_format) begin
              if (b == CH_HASH) begin
                in_comment_next = 1'b1;
              end else if (is_digit) begin
                if (d > 4'd1) begin
                  phase_next     = PH_IDLE;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_DIGIT;
                  res.last       = 1'b1;
                end else if (bits_new != 3'd0 && col_inc < width_reg) begin
                  pack_shift_next   = shift_new;
                  bits_packed_next  = bits_new;
                  column_count_next = col_inc;
                end else begin
                  pack_shift_next  = '0;
                  bits_packed_next = '0;
                  if (col_inc < width_reg) begin
                    column_count_next = col_inc;
                    res_valid         = 1'b1;
                    res.kind          = KIND_PIXEL;
                    res.pixel_byte    = shift_new;
                  end else begin
                    row_end = 1'b1;
                    row_pix = shift_new;
                  end
                end
              end
            end else begin
              if (col_inc < bytes_per_row) begin
                column_count_next = col_inc;
                res_valid         = 1'b1;
                res.kind          = KIND_PIXEL;
                res.pixel_byte    = b;
              end else begin
                row_end = 1'b1;
                row_pix = b & pad_mask;
              end
            end
            if (row_end) begin
              column_count_next = '0;
              row_count_next    = row_inc;
              res_valid         = 1'b1;
              res.kind          = KIND_PIXEL;
              res.pixel_byte    = row_pix;
              res.last          = (row_inc >= height_reg);
              if (row_inc >= height_reg) begin
                phase_next = PH_IDLE;
              end
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_MAGIC_P;
      ascii_format <= 1'b0;
      in_comment   <= 1'b0;
      number_accum <= '0;
      width_reg    <= '0;
      height_reg   <= '0;
      column_count <= '0;
      row_count    <= '0;
      bits_packed  <= '0;
      pack_shift   <= '0;
    end else begin
      phase        <= phase_next;
      ascii_format <= ascii_format_next;
      in_comment   <= in_comment_next;
      number_accum <= number_accum_next;
      width_reg    <= width_reg_next;
      height_reg   <= height_reg_next;
      column_count <= column_count_next;
      row_count    <= row_count_next;
      bits_packed  <= bits_packed_next;
      pack_shift   <= pack_shift_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pbm_stream_parser_top.sv
// ----------------------------------------------------------------------------
// pbm_stream_parser_top
// PBM (P1/P4) byte-stream parser: header dimensions, packed pixel bytes
// with a last mark, and error results.
//
//   channel  dir  payload
//   item     in   in_byte[7:0], end_of_stream
//   result   out  kind, pixel_byte, img_width, img_height, error_code, last
//
// One byte per cycle sustained while the result channel is ready: input
// register, one pass of parser logic, result register.
// Bytes that produce no result leave nothing in the result register.
// A stalled result holds its register; the input register still takes a
// new byte while it is empty. Reset clears both valid flags and the parser
// state back to waiting for the magic.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pbm_stream_parser_top_assert.svh"

module pbm_stream_parser_top #(
  parameter int MAX_DIM = pbm_pkg::MAX_DIM_DEFAULT
) (
  input wire logic     clk,
  input wire logic     rst,
  pbm_stream_if.sink   item,
  pbm_stream_if.source result
);

  import pbm_pkg::*;

  logic      in_q_valid;
  in_item_t  in_q;
  logic      res_valid;
  res_item_t res_q;
  logic      core_go;
  logic      core_res_valid;
  res_item_t core_res;

  assign core_go      = in_q_valid && (!res_valid || result.ready);
  assign item.ready   = !in_q_valid || core_go;
  assign result.valid = res_valid;
  assign result.data  = res_q;

  pbm_parser_core #(
    .MAX_DIM (MAX_DIM)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (core_go),
    .item      (in_q),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (item.ready) begin
        in_q_valid <= item.valid;
      end
      if (core_go) begin
        res_valid <= core_res_valid;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
    if (item.valid && item.ready) begin
      in_q <= item.data;
    end
    if (core_go && core_res_valid) begin
      res_q <= core_res;
    end
  end

  `PBM_ASSERT_NOW(a_error_is_last, clk, rst,
    result.valid && result.data.kind == KIND_ERROR, result.data.last)
  `PBM_ASSERT_NOW(a_pixel_fields_clear, clk, rst,
    result.valid && result.data.kind == KIND_PIXEL,
    result.data.img_width == '0 && result.data.img_height == '0 &&
    result.data.error_code == ERR_MAGIC)
  `PBM_ASSERT_NEXT(a_input_stage_holds, clk, rst,
    in_q_valid && !core_go, in_q_valid && $stable(in_q))

endmodule

`default_nettype wire

>>> tb/pbm_stream_parser_checker.sv
// ----------------------------------------------------------------------------
// PBM stream parser checker
// Watches the item and result channels of the parser, keeps its own model
// of the header, raster and error handling, and compares every result beat
// field by field with the oldest predicted result. Mismatch, pending and
// coverage counts go back to the testbench top.
// ----------------------------------------------------------------------------
module pbm_stream_parser_checker #(
  parameter int MAX_DIM = pbm_pkg::MAX_DIM_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  pbm_pkg::in_item_t  item_data,
  input  logic               res_valid,
  input  logic               res_ready,
  input  pbm_pkg::res_item_t res_data,
  output int                 mismatches,
  output int                 pending,
  output int                 checked,
  output int                 headers,
  output int                 errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import pbm_pkg::*;

  typedef enum logic [3:0] {
    ST_HUNT_P,
    ST_HUNT_TYPE,
    ST_W_GAP,
    ST_W_DIGITS,
    ST_H_GAP,
    ST_H_DIGITS,
    ST_PIXELS,
    ST_DRAINED
  } parse_state_t;

  parse_state_t state;
  bit           ascii_raster;
  bit           comment_on;
  int           num_acc;
  int           width_val;
  int           height_val;
  int           col_cnt;
  int           row_cnt;
  bit [2:0]     bit_idx;
  bit [7:0]     pack_acc;

  res_item_t    due_results[$];
  res_item_t    want;
  res_item_t    fresh;
  int           mism_cnt;
  int           n_checked;
  int           n_headers;
  int           n_errors;

  function automatic void rearm_parser();
    state        = ST_HUNT_P;
    ascii_raster = 1'b0;
    comment_on   = 1'b0;
    num_acc      = 0;
    width_val    = 0;
    height_val   = 0;
    col_cnt      = 0;
    row_cnt      = 0;
    bit_idx      = '0;
    pack_acc     = '0;
  endfunction

  function automatic res_item_t make_result(kind_t k, logic [7:0] pix, int w, int h,
                                            err_t e, bit last);
    res_item_t r;
    r.kind       = k;
    r.pixel_byte = pix;
    r.img_width  = w[DIM_OUT_W-1:0];
    r.img_height = h[DIM_OUT_W-1:0];
    r.error_code = e;
    r.last       = last;
    return r;
  endfunction

  function automatic res_item_t abort_with(err_t e);
    state = ST_DRAINED;
    return make_result(KIND_ERROR, 8'h00, 0, 0, e, 1'b1);
  endfunction

  function automatic res_item_t header_result();
    bit empty;
    empty    = (width_val == 0) || (height_val == 0);
    state    = empty ? ST_DRAINED : ST_PIXELS;
    col_cnt  = 0;
    row_cnt  = 0;
    bit_idx  = '0;
    pack_acc = '0;
    return make_result(KIND_HEADER, 8'h00, width_val, height_val, ERR_MAGIC, empty);
  endfunction

  function automatic bit parse_byte(input in_item_t it, output res_item_t res);
    logic [7:0] b;
    bit         is_digit;
    int         d;
    int         v;
    int         row_bytes;
    bit         row_end;
    logic [7:0] pix;
    b        = it.in_byte;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    d        = int'(b) - int'(CH_ZERO);
    res      = '0;
    pix      = '0;

    if (it.end_of_stream) begin
      if (state == ST_HUNT_P || state == ST_DRAINED) begin
        rearm_parser();
        return 1'b0;
      end
      if (state == ST_H_DIGITS && !comment_on && (width_val == 0 || num_acc == 0)) begin
        height_val = num_acc;
        res = header_result();
        rearm_parser();
        return 1'b1;
      end
      rearm_parser();
      res = make_result(KIND_ERROR, 8'h00, 0, 0, ERR_TRUNCATED, 1'b1);
      return 1'b1;
    end

    case (state)
      ST_HUNT_P: begin
        if (b != CH_P) begin
          res = abort_with(ERR_MAGIC);
          return 1'b1;
        end
        state = ST_HUNT_TYPE;
        return 1'b0;
      end
      ST_HUNT_TYPE: begin
        if (b == CH_ONE) begin
          ascii_raster = 1'b1;
        end else if (b == CH_FOUR) begin
          ascii_raster = 1'b0;
        end else begin
          res = abort_with(ERR_FORMAT);
          return 1'b1;
        end
        comment_on = 1'b0;
        state      = ST_W_GAP;
        return 1'b0;
      end
      ST_W_GAP, ST_H_GAP: begin
        if (comment_on) begin
          if (b == CH_NEWLINE) comment_on = 1'b0;
          return 1'b0;
        end
        if (b == CH_HASH) begin
          comment_on = 1'b1;
          return 1'b0;
        end
        if (!is_digit) return 1'b0;
        if (d > MAX_DIM) begin
          res = abort_with(ERR_LARGE);
          return 1'b1;
        end
        num_acc = d;
        state   = (state == ST_W_GAP) ? ST_W_DIGITS : ST_H_DIGITS;
        return 1'b0;
      end
      ST_W_DIGITS, ST_H_DIGITS: begin
        if (is_digit) begin
          v = num_acc * 10 + d;
          if (v > MAX_DIM) begin
            res = abort_with(ERR_LARGE);
            return 1'b1;
          end
          num_acc = v;
          return 1'b0;
        end
        if (b == CH_HASH) comment_on = 1'b1;
        if (state == ST_W_DIGITS) begin
          width_val = num_acc;
          num_acc   = 0;
          state     = ST_H_GAP;
          return 1'b0;
        end
        height_val = num_acc;
        num_acc    = 0;
        res = header_result();
        return 1'b1;
      end
      ST_PIXELS: begin
        if (comment_on) begin
          if (b == CH_NEWLINE) comment_on = 1'b0;
          return 1'b0;
        end
        if (ascii_raster) begin
          if (b == CH_HASH) begin
            comment_on = 1'b1;
            return 1'b0;
          end
          if (!is_digit) return 1'b0;
          if (d > 1) begin
            res = abort_with(ERR_DIGIT);
            return 1'b1;
          end
          if (d == 1) pack_acc[3'd7 - bit_idx] = 1'b1;
          bit_idx = bit_idx + 3'd1;
          col_cnt++;
          if (bit_idx != 3'd0 && col_cnt < width_val) return 1'b0;
          pix      = pack_acc;
          pack_acc = '0;
          bit_idx  = '0;
          if (col_cnt < width_val) begin
            res = make_result(KIND_PIXEL, pix, 0, 0, ERR_MAGIC, 1'b0);
            return 1'b1;
          end
        end else begin
          row_bytes = (width_val + 7) / 8;
          pix       = b;
          col_cnt++;
          if (col_cnt < row_bytes) begin
            res = make_result(KIND_PIXEL, pix, 0, 0, ERR_MAGIC, 1'b0);
            return 1'b1;
          end
          if (width_val % 8 != 0) pix = pix & (8'hFF << (8 - width_val % 8));
        end
        col_cnt = 0;
        row_cnt++;
        row_end = (row_cnt >= height_val);
        if (row_end) state = ST_DRAINED;
        res = make_result(KIND_PIXEL, pix, 0, 0, ERR_MAGIC, row_end);
        return 1'b1;
      end
      default: begin
        state = ST_DRAINED;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic flag_mismatch(string why, res_item_t exp_r, res_item_t got_r);
    mism_cnt++;
    if (mism_cnt <= 10)
      $display("%0t: %s: expected kind=%0d pix=%02h w=%0d h=%0d err=%0d last=%0b,",
               $realtime, why, exp_r.kind, exp_r.pixel_byte, exp_r.img_width,
               exp_r.img_height, exp_r.error_code, exp_r.last,
               " got kind=%0d pix=%02h w=%0d h=%0d err=%0d last=%0b",
               got_r.kind, got_r.pixel_byte, got_r.img_width, got_r.img_height,
               got_r.error_code, got_r.last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rearm_parser();
      due_results.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (due_results.size() == 0) begin
          flag_mismatch("unexpected result beat", '0, res_data);
        end else begin
          want = due_results.pop_front();
          if (res_data.kind !== want.kind || res_data.pixel_byte !== want.pixel_byte ||
              res_data.img_width !== want.img_width ||
              res_data.img_height !== want.img_height ||
              res_data.error_code !== want.error_code || res_data.last !== want.last)
            flag_mismatch("result beat differs", want, res_data);
          n_checked++;
          if (want.kind == KIND_HEADER) n_headers++;
          if (want.kind == KIND_ERROR) n_errors++;
        end
      end
      if (item_valid && item_ready && parse_byte(item_data, fresh))
        due_results.push_back(fresh);
    end
    mismatches <= mism_cnt;
    pending    <= due_results.size();
    checked    <= n_checked;
    headers    <= n_headers;
    errors     <= n_errors;
  end

endmodule

>>> tb/pbm_stream_parser_top_tb.sv
// ----------------------------------------------------------------------------
// PBM stream parser testbench
// Feeds short directed files, then random P1/P4 bitmap files with comments,
// odd separators, empty and oversized dimensions, bad digits, truncation and
// noise, through the item channel in bursts. The result channel stalls on
// shifting patterns; a checker module predicts and compares every beat.
// ----------------------------------------------------------------------------
module pbm_stream_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pbm_pkg::*;

  localparam int ITEM_TARGET = 1800;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int chk_mismatches;
  int chk_pending;
  int chk_checked;
  int chk_headers;
  int chk_errors;

  in_item_t file_q[$];
  int       burst_left;
  int       items_counted;
  int       files_sent;
  int       beats_sent;
  int       cycles;
  int       stall_mode;
  int       mode_left;

  always #5 clk = ~clk;

  pbm_stream_if #(.payload_t(in_item_t))  item_ch ();
  pbm_stream_if #(.payload_t(res_item_t)) result_ch ();

  pbm_stream_parser_top dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  pbm_stream_parser_checker chk (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_ch.valid),
    .item_ready (item_ch.ready),
    .item_data  (item_ch.data),
    .res_valid  (result_ch.valid),
    .res_ready  (result_ch.ready),
    .res_data   (result_ch.data),
    .mismatches (chk_mismatches),
    .pending    (chk_pending),
    .checked    (chk_checked),
    .headers    (chk_headers),
    .errors     (chk_errors)
  );

  function automatic void add_byte(logic [7:0] b);
    file_q.push_back('{in_byte: b, end_of_stream: 1'b0});
  endfunction

  function automatic void add_eos();
    file_q.push_back('{in_byte: 8'($urandom), end_of_stream: 1'b1});
  endfunction

  function automatic void add_text(string s);
    foreach (s[i]) add_byte(s[i]);
  endfunction

  function automatic void add_number(int v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) s = {"0", s};
    add_text(s);
  endfunction

  function automatic void add_comment();
    logic [7:0] c;
    add_byte(CH_HASH);
    repeat ($urandom_range(0, 6)) begin
      c = 8'($urandom);
      if (c == CH_NEWLINE) c = 8'h20;
      add_byte(c);
    end
    add_byte(CH_NEWLINE);
  endfunction

  function automatic void add_gap(int min_len);
    repeat ($urandom_range(min_len, 3)) begin
      case ($urandom_range(0, 7))
        0: add_comment();
        1: add_byte(8'(8'h41 + $urandom_range(0, 25)));
        2: add_byte(8'h09);
        3: add_byte(CH_NEWLINE);
        4: add_byte(8'h0D);
        default: add_byte(8'h20);
      endcase
    end
  endfunction

  function automatic void add_delim();
    case ($urandom_range(0, 5))
      0: add_comment();
      1: add_byte(CH_NEWLINE);
      default: add_byte(8'h20);
    endcase
  endfunction

  function automatic void load_directed();
    add_eos();
    add_byte(8'h00);
    add_eos();
    add_byte(CH_P);
    add_byte(8'hFF);
    add_eos();
    add_text("P4 0 5");
    add_eos();
    add_text("P12#\n1\n19");
    add_eos();
    add_text("P11 1 9");
    add_eos();
    add_text("P420000");
    add_eos();
  endfunction

  function automatic int build_file();
    int r;
    int w;
    int h;
    int kept;
    int cut;
    int bad_at;
    bit ascii;
    bit bad;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
      add_eos();
      return file_q.size();
    end
    ascii = 1'($urandom_range(0, 1));
    add_byte(CH_P);
    add_byte(ascii ? CH_ONE : CH_FOUR);
    add_gap(0);
    if (r < 14) begin
      if ($urandom_range(0, 1) == 0) begin
        add_number($urandom_range(1, 40));
        add_gap(1);
      end
      add_number(($urandom_range(0, 2) == 0) ? MAX_DIM_DEFAULT + 1 :
                 $urandom_range(MAX_DIM_DEFAULT + 1, 99999));
      kept = file_q.size();
      add_eos();
      return kept;
    end
    if (r < 20) begin
      w = ($urandom_range(0, 1) == 0) ? MAX_DIM_DEFAULT : $urandom_range(0, MAX_DIM_DEFAULT);
      h = 0;
      if ($urandom_range(0, 1) == 1) begin
        h = w;
        w = 0;
      end
      add_number(w);
      add_gap(1);
      add_number(h);
      if ($urandom_range(0, 1) == 0) add_delim();
      kept = file_q.size();
      add_eos();
      return kept;
    end
    if (ascii) w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 16);
    else if ($urandom_range(0, 29) == 0) w = $urandom_range(100, 300);
    else w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 40);
    h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
    add_number(w);
    add_gap(1);
    add_number(h);
    add_delim();
    if (w > 0 && h > 0) begin
      if (ascii) begin
        bad    = ($urandom_range(0, 9) == 0);
        bad_at = $urandom_range(0, w * h - 1);
        for (int p = 0; p < w * h; p++) begin
          if (bad && p == bad_at) add_byte(8'(CH_ZERO + $urandom_range(2, 9)));
          else add_byte(($urandom_range(0, 1) == 1) ? CH_ONE : CH_ZERO);
          if ($urandom_range(0, 3) == 0) add_gap(1);
        end
      end else begin
        repeat (((w + 7) / 8) * h) add_byte(8'($urandom));
      end
    end
    // cut the file short
    if ($urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
    kept = file_q.size();
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 5)) add_byte(8'($urandom));
    add_eos();
    return kept;
  endfunction

  task automatic send_beat(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                                                 $urandom_range(1, 12);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_file();
    while (file_q.size() > 0) begin
      send_beat(file_q.pop_front());
      beats_sent++;
    end
  endtask

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: result_ch.ready <= 1'b1;
      1: result_ch.ready <= ($urandom_range(0, 3) != 0);
      2: result_ch.ready <= ($urandom_range(0, 3) == 0);
      default: result_ch.ready <= ((mode_left % 6) < 3);
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles, chk_pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    item_ch.valid   = 1'b0;
    item_ch.data    = '0;
    result_ch.ready = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    load_directed();
    items_counted = file_q.size();
    send_file();
    while (items_counted < ITEM_TARGET) begin
      items_counted += build_file();
      files_sent++;
      send_file();
    end
    item_ch.valid <= 1'b0;

    // drain
    while (chk_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d random files and the directed set, %0d input beats in all",
             files_sent, beats_sent);
    $display("Checked %0d result beats: %0d headers, %0d errors, %0d mismatches",
             chk_checked, chk_headers, chk_errors, chk_mismatches);
    if (chk_mismatches == 0 && chk_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/pbm_pkg.sv
rtl/pbm_stream_if.sv
rtl/pbm_parser_core.sv
rtl/pbm_stream_parser_top.sv
tb/pbm_stream_parser_checker.sv
tb/pbm_stream_parser_top_tb.sv
